>>> sv/pdrq_pkg.sv
// pdrq_pkg: sizes, entry and result types and the ordering function of the
// priority deadline request queue; no dependencies
package pdrq_pkg;

	localparam int DEPTH   = 64;
	localparam int PRIO_W  = 8;
	localparam int DL_W    = 32;
	localparam int TAG_W   = 16;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [DL_W-1:0]   dl;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic              out_valid;
		logic [PRIO_W-1:0] prio;
		logic [DL_W-1:0]   dl;
		logic [TAG_W-1:0]  tag;
		logic              refused;
		logic              empty;
		logic [CNT_W-1:0]  count;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT
	} state_t;

	// true when entry a must leave before the older entry b
	function automatic logic beats(input entry_t a, input entry_t b);
		logic r;
		if (a.prio != b.prio) begin
			r = (a.prio > b.prio);
		end else begin
			r = (a.dl < b.dl);
		end
		return r;
	endfunction

endpackage

>>> sv/pdrq_ram.sv
// pdrq_ram: generic single write, single read memory with registered read data
// no dependencies
module pdrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> sv/priority_deadline_request_queue.sv
// priority_deadline_request_queue: top level of the request scheduler queue
// depends on pdrq_pkg and pdrq_ram
//
// usage
// - input channel (in_valid/in_ready) takes one word per access: operation
//   selects push or pop; priority_req, deadline and request_tag matter on push
// - result channel (res_valid/res_ready) gives exactly one word per access:
//   the popped request (out_valid high) or zeros, push_refused, queue_empty
//   and pending_count after the access
// - entries sit in a memory in arrival order; a pop scans all pending entries
//   through one shared comparator (one entry per cycle, registered memory read)
//   and then closes the gap by moving each later entry down one slot
// - results: push, refused push and pop from empty give their word on the
//   cycle after acceptance; a pop gives its word once the scan and then the
//   shift have run through the pending entries
// - throughput: the next access is taken in the cycle the word leaves, so one
//   push per cycle at best; a pop holds off the next access until its word is out
// - in_ready is high only while the sequencer is idle and the result register
//   is free or being emptied; a stalled receiver holds the result word, and the
//   result register is always free by the time a pop finishes
// - reset empties the queue; memory contents are never cleared, since only
//   data from slots below the count is ever used
module priority_deadline_request_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       operation,
	input  logic [pdrq_pkg::PRIO_W-1:0] priority_req,
	input  logic [pdrq_pkg::DL_W-1:0]   deadline,
	input  logic [pdrq_pkg::TAG_W-1:0]  request_tag,
	output logic                       res_valid,
	input  logic                       res_ready,
	output logic                       out_valid,
	output logic [pdrq_pkg::PRIO_W-1:0] out_priority,
	output logic [pdrq_pkg::DL_W-1:0]   out_deadline,
	output logic [pdrq_pkg::TAG_W-1:0]  out_tag,
	output logic                       push_refused,
	output logic                       queue_empty,
	output logic [pdrq_pkg::CNT_W-1:0]  pending_count
);

	localparam int IDX_W = pdrq_pkg::IDX_W;
	localparam int CNT_W = pdrq_pkg::CNT_W;

	// sequencer and bookkeeping
	pdrq_pkg::state_t  state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  scan_q, scan_d;       // next slot to read during the scan
	logic              data_vld_q, data_vld_d;
	logic [IDX_W-1:0]  data_idx_q, data_idx_d; // slot whose data is on rdata
	pdrq_pkg::entry_t  best_q, best_d;
	logic [IDX_W-1:0]  best_idx_q, best_idx_d;
	logic [CNT_W-1:0]  src_q, src_d;         // next slot to read during the shift
	logic              wvld_q, wvld_d;
	logic [IDX_W-1:0]  widx_q, widx_d;

	// result register
	logic              res_valid_q, res_valid_d;
	pdrq_pkg::result_t res_q, res_d;

	// memory port signals
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	pdrq_pkg::entry_t  mem_wdata;
	logic [IDX_W-1:0]  mem_raddr;
	logic [pdrq_pkg::ENTRY_W-1:0] mem_rdata;
	pdrq_pkg::entry_t  rd_entry;

	// shared compare unit
	logic              take;
	pdrq_pkg::entry_t  new_best;
	logic [IDX_W-1:0]  new_idx;
	logic              scan_last;
	logic              out_free;
	logic              accept;

	assign rd_entry = pdrq_pkg::entry_t'(mem_rdata);
	assign out_free = !res_valid_q || res_ready;
	assign in_ready = (state_q == pdrq_pkg::ST_IDLE) && out_free;
	assign accept   = in_valid && in_ready;

	// first entry seeds the winner; a later one must strictly beat it
	assign take      = data_vld_q
		&& ((data_idx_q == '0) || pdrq_pkg::beats(rd_entry, best_q));
	assign new_best  = take ? rd_entry : best_q;
	assign new_idx   = take ? data_idx_q : best_idx_q;
	assign scan_last = data_vld_q && ({1'b0, data_idx_q} == (count_q - CNT_W'(1)));

	pdrq_ram #(
		.WIDTH (pdrq_pkg::ENTRY_W),
		.DEPTH (pdrq_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pdrq_pkg::ST_IDLE;
			count_q     <= '0;
			data_vld_q  <= 1'b0;
			wvld_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			data_vld_q  <= data_vld_d;
			wvld_q      <= wvld_d;
			res_valid_q <= res_valid_d;
		end
	end

	// payload and index registers need no reset
	always_ff @(posedge clk) begin
		scan_q     <= scan_d;
		data_idx_q <= data_idx_d;
		best_q     <= best_d;
		best_idx_q <= best_idx_d;
		src_q      <= src_d;
		widx_q     <= widx_d;
		res_q      <= res_d;
	end

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		scan_d      = scan_q;
		data_vld_d  = 1'b0;
		data_idx_d  = data_idx_q;
		best_d      = best_q;
		best_idx_d  = best_idx_q;
		src_d       = src_q;
		wvld_d      = 1'b0;
		widx_d      = widx_q;
		res_valid_d = res_valid_q && !res_ready;
		res_d       = res_q;

		mem_we    = 1'b0;
		mem_waddr = widx_q;
		mem_wdata = rd_entry;
		mem_raddr = scan_q[IDX_W-1:0];

		case (state_q)
			pdrq_pkg::ST_IDLE: begin
				if (accept) begin
					res_d = '0;
					if (operation == pdrq_pkg::OP_PUSH) begin
						res_valid_d = 1'b1;
						if (count_q == CNT_W'(pdrq_pkg::DEPTH)) begin
							// full: drop the request
							res_d.refused = 1'b1;
							res_d.count   = count_q;
						end else begin
							mem_we         = 1'b1;
							mem_waddr      = count_q[IDX_W-1:0];
							mem_wdata.prio = priority_req;
							mem_wdata.dl   = deadline;
							mem_wdata.tag  = request_tag;
							count_d        = count_q + CNT_W'(1);
							res_d.count    = count_q + CNT_W'(1);
						end
						res_d.empty = 1'b0;
						if (count_q == '0 && res_d.refused) begin
							res_d.empty = 1'b1;
						end
					end else if (count_q == '0) begin
						// pop from empty queue
						res_valid_d = 1'b1;
						res_d.empty = 1'b1;
					end else begin
						scan_d  = '0;
						state_d = pdrq_pkg::ST_SCAN;
					end
				end
			end

			pdrq_pkg::ST_SCAN: begin
				mem_raddr = scan_q[IDX_W-1:0];
				if (scan_q < count_q) begin
					scan_d     = scan_q + CNT_W'(1);
					data_vld_d = 1'b1;
					data_idx_d = scan_q[IDX_W-1:0];
				end
				if (data_vld_q) begin
					best_d     = new_best;
					best_idx_d = new_idx;
				end
				if (scan_last) begin
					src_d   = CNT_W'(new_idx) + CNT_W'(1);
					state_d = pdrq_pkg::ST_SHIFT;
				end
			end

			pdrq_pkg::ST_SHIFT: begin
				// read slot src, write it one slot down on the next cycle
				mem_raddr = src_q[IDX_W-1:0];
				mem_we    = wvld_q;
				mem_waddr = widx_q;
				mem_wdata = rd_entry;
				if (src_q < count_q) begin
					src_d  = src_q + CNT_W'(1);
					wvld_d = 1'b1;
					widx_d = IDX_W'(src_q - CNT_W'(1));
				end else if (!wvld_q && out_free) begin
					res_valid_d     = 1'b1;
					res_d.out_valid = 1'b1;
					res_d.prio      = best_q.prio;
					res_d.dl        = best_q.dl;
					res_d.tag       = best_q.tag;
					res_d.refused   = 1'b0;
					res_d.count     = count_q - CNT_W'(1);
					res_d.empty     = (count_q == CNT_W'(1));
					count_d         = count_q - CNT_W'(1);
					state_d         = pdrq_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = pdrq_pkg::ST_IDLE;
			end
		endcase
	end

	assign res_valid     = res_valid_q;
	assign out_valid     = res_q.out_valid;
	assign out_priority  = res_q.prio;
	assign out_deadline  = res_q.dl;
	assign out_tag       = res_q.tag;
	assign push_refused  = res_q.refused;
	assign queue_empty   = res_q.empty;
	assign pending_count = res_q.count;

endmodule

>>> sv/pdrq_checker.sv
// pdrq_checker: port level assertions for the request queue, bound to the top
// depends on pdrq_pkg
module pdrq_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic                        out_valid,
	input logic                        push_refused,
	input logic                        queue_empty,
	input logic [pdrq_pkg::CNT_W-1:0]  pending_count
);

	// a result word waits for the receiver
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped while stalled");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (queue_empty == (pending_count == '0)))
		else $error("empty flag disagrees with count");

	a_pop_not_refused: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && out_valid |-> !push_refused)
		else $error("popped word flagged as refused push");

	a_refused_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && push_refused
		|-> pending_count == pdrq_pkg::CNT_W'(pdrq_pkg::DEPTH))
		else $error("push refused while queue not full");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pending_count <= pdrq_pkg::CNT_W'(pdrq_pkg::DEPTH))
		else $error("count beyond depth");

endmodule

bind priority_deadline_request_queue pdrq_checker u_pdrq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res_valid),
	.res_ready     (res_ready),
	.out_valid     (out_valid),
	.push_refused  (push_refused),
	.queue_empty   (queue_empty),
	.pending_count (pending_count)
);

>>> verif/pdrq_order_checker.sv
// pdrq_order_checker: watches both channels of the request queue, keeps its own
// copy of the pending requests and compares every result word with its prediction
// depends on pdrq_pkg
module pdrq_order_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        operation,
	input  logic [pdrq_pkg::PRIO_W-1:0] priority_req,
	input  logic [pdrq_pkg::DL_W-1:0]   deadline,
	input  logic [pdrq_pkg::TAG_W-1:0]  request_tag,
	input  logic                        res_valid,
	input  logic                        res_ready,
	input  logic                        out_valid,
	input  logic [pdrq_pkg::PRIO_W-1:0] out_priority,
	input  logic [pdrq_pkg::DL_W-1:0]   out_deadline,
	input  logic [pdrq_pkg::TAG_W-1:0]  out_tag,
	input  logic                        push_refused,
	input  logic                        queue_empty,
	input  logic [pdrq_pkg::CNT_W-1:0]  pending_count,
	output int                          fail_count,
	output int                          pending_words,
	output int                          stored_pushes,
	output int                          refused_pushes,
	output int                          served_pops,
	output int                          empty_pops,
	output int                          peak_level
);

	pdrq_pkg::entry_t  held_requests[$];
	pdrq_pkg::result_t awaited_words[$];
	pdrq_pkg::result_t oldest_word;
	pdrq_pkg::result_t predicted;
	pdrq_pkg::entry_t  arriving;

	// applies one access to the held requests and returns the word it must produce
	function automatic pdrq_pkg::result_t serve_access(input logic op,
	                                                   input pdrq_pkg::entry_t req);
		pdrq_pkg::result_t r;
		int                best;
		r = '0;
		if (op == pdrq_pkg::OP_PUSH) begin
			if (held_requests.size() >= pdrq_pkg::DEPTH) begin
				r.refused = 1'b1;
				refused_pushes++;
			end else begin
				held_requests.insert(held_requests.size(), req);
				stored_pushes++;
			end
		end else if (held_requests.size() > 0) begin
			best = 0;
			// strict compares keep the older request on an exact tie
			for (int i = 1; i < held_requests.size(); i++) begin
				if (held_requests[i].prio > held_requests[best].prio ||
				    (held_requests[i].prio == held_requests[best].prio &&
				     held_requests[i].dl < held_requests[best].dl)) begin
					best = i;
				end
			end
			r.out_valid = 1'b1;
			r.prio      = held_requests[best].prio;
			r.dl        = held_requests[best].dl;
			r.tag       = held_requests[best].tag;
			held_requests.delete(best);
			served_pops++;
		end else begin
			empty_pops++;
		end
		r.empty = (held_requests.size() == 0);
		r.count = pdrq_pkg::CNT_W'(held_requests.size());
		if (held_requests.size() > peak_level) begin
			peak_level = held_requests.size();
		end
		return r;
	endfunction

	task automatic check_field(input string fname, input logic [31:0] want,
	                           input logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_requests.delete();
			awaited_words.delete();
			fail_count     = 0;
			pending_words  = 0;
			stored_pushes  = 0;
			refused_pushes = 0;
			served_pops    = 0;
			empty_pops     = 0;
			peak_level     = 0;
		end else begin
			if (res_valid && res_ready) begin
				if (awaited_words.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result word, valid %0b tag %0h count %0d",
					         $time, out_valid, out_tag, pending_count);
				end else begin
					oldest_word = awaited_words.pop_front();
					check_field("out_valid", 32'(oldest_word.out_valid), 32'(out_valid));
					check_field("out_priority", 32'(oldest_word.prio), 32'(out_priority));
					check_field("out_deadline", oldest_word.dl, out_deadline);
					check_field("out_tag", 32'(oldest_word.tag), 32'(out_tag));
					check_field("push_refused", 32'(oldest_word.refused),
					            32'(push_refused));
					check_field("queue_empty", 32'(oldest_word.empty), 32'(queue_empty));
					check_field("pending_count", 32'(oldest_word.count),
					            32'(pending_count));
				end
			end
			if (in_valid && in_ready) begin
				arriving  = {priority_req, deadline, request_tag};
				predicted = serve_access(operation, arriving);
				awaited_words.insert(awaited_words.size(), predicted);
			end
			pending_words = awaited_words.size();
		end
	end

endmodule

>>> verif/tb_top.sv
// tb_top: stimulus, clock, reset and verdict for priority_deadline_request_queue
// depends on pdrq_pkg, the block itself and pdrq_order_checker
module tb_top;

	localparam int DEPTH  = pdrq_pkg::DEPTH;
	localparam int PRIO_W = pdrq_pkg::PRIO_W;
	localparam int DL_W   = pdrq_pkg::DL_W;
	localparam int TAG_W  = pdrq_pkg::TAG_W;
	localparam int CNT_W  = pdrq_pkg::CNT_W;

	localparam int RANDOM_WORDS = 1200;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int IDLE_PCT     = 34;
	// a pop over a full queue scans all DEPTH slots and then shifts the later ones down
	localparam int SETTLE_WAIT  = 2 * DEPTH + 16;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              operation;
	logic [PRIO_W-1:0] priority_req;
	logic [DL_W-1:0]   deadline;
	logic [TAG_W-1:0]  request_tag;
	logic              res_valid;
	logic              res_ready;
	logic              out_valid;
	logic [PRIO_W-1:0] out_priority;
	logic [DL_W-1:0]   out_deadline;
	logic [TAG_W-1:0]  out_tag;
	logic              push_refused;
	logic              queue_empty;
	logic [CNT_W-1:0]  pending_count;

	// random idling on both sides, switched off for one stretch of the run
	logic idle_en;

	int fail_count;
	int pending_words;
	int stored_pushes;
	int refused_pushes;
	int served_pops;
	int empty_pops;
	int peak_level;

	priority_deadline_request_queue uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.priority_req  (priority_req),
		.deadline      (deadline),
		.request_tag   (request_tag),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.out_valid     (out_valid),
		.out_priority  (out_priority),
		.out_deadline  (out_deadline),
		.out_tag       (out_tag),
		.push_refused  (push_refused),
		.queue_empty   (queue_empty),
		.pending_count (pending_count)
	);

	pdrq_order_checker order_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.priority_req   (priority_req),
		.deadline       (deadline),
		.request_tag    (request_tag),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.out_valid      (out_valid),
		.out_priority   (out_priority),
		.out_deadline   (out_deadline),
		.out_tag        (out_tag),
		.push_refused   (push_refused),
		.queue_empty    (queue_empty),
		.pending_count  (pending_count),
		.fail_count     (fail_count),
		.pending_words  (pending_words),
		.stored_pushes  (stored_pushes),
		.refused_pushes (refused_pushes),
		.served_pops    (served_pops),
		.empty_pops     (empty_pops),
		.peak_level     (peak_level)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver side: ready known from time zero, then changes only at the falling edge
	initial begin
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			res_ready <= !idle_en || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// watchdog: a hung block or a lost word ends the run here
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d words still expected", CYCLE_LIMIT,
		         pending_words);
		$display("CHECKS FAILED");
		$finish;
	end

	// offers one word at a falling edge and returns at the falling edge after it
	// was taken; valid stays up with the same payload until in_ready is seen
	task automatic send_word(input logic op, input logic [PRIO_W-1:0] p,
	                         input logic [DL_W-1:0] d, input logic [TAG_W-1:0] t);
		while (idle_en && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= op;
		priority_req <= p;
		deadline     <= d;
		request_tag  <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// holds the sender back until every expected word has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_words != 0) @(negedge clk);
	endtask

	initial begin
		logic              op;
		logic [PRIO_W-1:0] p;
		logic [DL_W-1:0]   d;
		logic [TAG_W-1:0]  t;
		int                sent;
		int                phase_no;
		int                phase_len;
		int                push_pct;

		// every input known from time zero, reset released at a falling edge
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		operation    = pdrq_pkg::OP_PUSH;
		priority_req = '0;
		deadline     = '0;
		request_tag  = '0;
		idle_en      = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: pop on an empty queue
		send_word(pdrq_pkg::OP_POP, '0, '0, '0);
		// field extremes
		send_word(pdrq_pkg::OP_PUSH, 8'h00, 32'hFFFF_FFFF, 16'h0000);
		send_word(pdrq_pkg::OP_PUSH, 8'hFF, 32'h0000_0000, 16'hFFFF);
		// exact tie with the previous word, the older one must leave first
		send_word(pdrq_pkg::OP_PUSH, 8'hFF, 32'h0000_0000, 16'h1234);
		send_word(pdrq_pkg::OP_PUSH, 8'hFF, 32'h0000_0005, 16'h00A5);
		// equal priority, deadline decides
		send_word(pdrq_pkg::OP_PUSH, 8'h07, 32'h0000_0064, 16'h0A0A);
		send_word(pdrq_pkg::OP_PUSH, 8'h07, 32'h0000_0032, 16'h0B0B);
		send_word(pdrq_pkg::OP_PUSH, 8'h07, 32'h0000_0032, 16'h0C0C);
		// drain all seven, then pop once more on empty
		repeat (8) send_word(pdrq_pkg::OP_POP, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
		// middle-of-range bit patterns
		send_word(pdrq_pkg::OP_PUSH, 8'h80, 32'h8000_0000, 16'h8000);
		send_word(pdrq_pkg::OP_PUSH, 8'h7F, 32'h7FFF_FFFF, 16'h7FFF);
		send_word(pdrq_pkg::OP_POP, 8'h55, 32'h5555_5555, 16'h5555);
		send_word(pdrq_pkg::OP_POP, 8'hAA, 32'hAAAA_AAAA, 16'hAAAA);
		send_word(pdrq_pkg::OP_POP, '0, '0, '0);

		// full stop before the random part
		wait_drained();

		// random part in phases: first a fill past full, then a drain past empty,
		// then mixed phases leaning either way
		sent     = 0;
		phase_no = 0;
		while (sent < RANDOM_WORDS) begin
			if (phase_no == 0) begin
				push_pct = 90;
			end else if (phase_no == 1) begin
				push_pct = 10;
			end else begin
				case ($urandom_range(3))
					0: push_pct = 90;
					1: push_pct = 10;
					2: push_pct = 55;
					default: push_pct = 45;
				endcase
			end
			phase_len = (phase_no < 2) ? 100 : $urandom_range(20, 120);
			for (int k = 0; k < phase_len && sent < RANDOM_WORDS; k++) begin
				// a stretch with no idling on either side
				if (sent == 500) begin
					idle_en <= 1'b0;
				end
				if (sent == 750) begin
					idle_en <= 1'b1;
				end
				// sender pause mid-run until everything has come back
				if (sent == 600) begin
					wait_drained();
				end
				op = ($urandom_range(99) < push_pct) ? pdrq_pkg::OP_PUSH : pdrq_pkg::OP_POP;
				// narrow pools make ties on priority and deadline common
				case ($urandom_range(3))
					0, 1: p = PRIO_W'($urandom);
					2: p = PRIO_W'($urandom_range(3));
					default: p = 8'hFC | PRIO_W'($urandom_range(3));
				endcase
				case ($urandom_range(3))
					0, 1: d = $urandom;
					2: d = $urandom_range(7);
					default: d = 32'hFFFF_FFF8 | $urandom_range(7);
				endcase
				t = TAG_W'($urandom);
				send_word(op, p, d, t);
				sent++;
			end
			phase_no++;
		end

		wait_drained();
		repeat (SETTLE_WAIT) @(negedge clk);

		$display("run covered %0d pushes stored and %0d refused on a full queue, peak level %0d",
		         stored_pushes, refused_pushes, peak_level);
		$display("and %0d pops returning a request plus %0d pops on an empty queue",
		         served_pops, empty_pops);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
